@@ rtl/contiguous_slot_first_fit_allocator_core_defines.svh @@
// Assertion macros shared by the allocator RTL.
// Both macros sample on clk and hold off while rst is high.
`ifndef CONTIGUOUS_SLOT_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_SLOT_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CSSFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define CSSFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cssfa_pkg.sv @@
package cssfa_pkg;

  // Default geometry of the occupancy map.
  localparam int DEF_MAX_ROWS  = 16;
  localparam int DEF_MAX_SLOTS = 128;

  // Fixed field widths.
  localparam int ID_W        = 10;
  localparam int WIDTH_W     = 8;
  localparam int ROW_W       = 4;
  localparam int SLOT_W      = 7;
  localparam int ST_W        = 2;
  localparam int STEP_W      = $clog2(WIDTH_W);
  localparam int CFG_ROWS_W  = 5;
  localparam int CFG_SLOTS_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_ROWS_W-1:0]  ROWS_RESET  = CFG_ROWS_W'(16);
  localparam logic [CFG_SLOTS_W-1:0] SLOTS_RESET = CFG_SLOTS_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_IN_USE  = 1'b0,
    REG_SLOTS_IN_USE = 1'b1
  } cfg_reg_t;

  typedef enum logic [ST_W-1:0] {
    ST_PLACED  = 2'd0,
    ST_NOROOM  = 2'd1,
    ST_SKIPPED = 2'd2,
    ST_BLOCKED = 2'd3
  } st_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic norm_start;
    logic norm_sub;
    logic row_init;
    logic rd_block;
    logic rd_row;
    logic blk_write;
    logic load;
    logic step;
    logic pick;
    logic row_next;
    logic encode;
    logic place_write;
    logic skip_clear;
    logic skip_arm;
    logic set_status;
    st_t  status_val;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_block;
    logic skip_hit;
    logic cur_ge_n;
    logic step_last;
    logic found;
    logic last_row;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/cssfa_ram.sv @@
module cssfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/cssfa_ctrl.sv @@
`include "contiguous_slot_first_fit_allocator_core_defines.svh"

module cssfa_ctrl import cssfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECIDE = 12'b0000_0000_0010,
    S_BRD    = 12'b0000_0000_0100,
    S_BWR    = 12'b0000_0000_1000,
    S_NORM   = 12'b0000_0001_0000,
    S_READ   = 12'b0000_0010_0000,
    S_LOAD   = 12'b0000_0100_0000,
    S_STEP   = 12'b0000_1000_0000,
    S_PICK   = 12'b0001_0000_0000,
    S_MARK   = 12'b0010_0000_0000,
    S_WRITE  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op_block) begin
          state_next = S_BRD;
        end else if (sts.skip_hit) begin
          cmd.skip_clear = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_val = ST_SKIPPED;
          state_next     = S_DONE;
        end else begin
          cmd.norm_start = 1'b1;
          cmd.skip_clear = 1'b1;
          state_next     = S_NORM;
        end
      end
      S_BRD: begin
        cmd.rd_block = 1'b1;
        state_next   = S_BWR;
      end
      S_BWR: begin
        cmd.blk_write  = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status_val = ST_BLOCKED;
        state_next     = S_DONE;
      end
      S_NORM: begin
        if (sts.cur_ge_n) begin
          cmd.norm_sub = 1'b1;
        end else begin
          cmd.row_init = 1'b1;
          state_next   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_row = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (sts.step_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        if (sts.found) begin
          state_next = S_MARK;
        end else if (sts.last_row) begin
          cmd.skip_arm   = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status_val = ST_NOROOM;
          state_next     = S_DONE;
        end else begin
          cmd.row_next = 1'b1;
          state_next   = S_READ;
        end
      end
      S_MARK: begin
        cmd.encode = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.place_write = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_val  = ST_PLACED;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `CSSFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted a word but stayed ready")

endmodule

@@ rtl/cssfa_dp.sv @@
`include "contiguous_slot_first_fit_allocator_core_defines.svh"

module cssfa_dp import cssfa_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   op,
  input  logic [ID_W-1:0]        item_id,
  input  logic [WIDTH_W-1:0]     run_width,
  input  logic [ROW_W-1:0]       block_row,
  input  logic [SLOT_W-1:0]      block_slot,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ST_W-1:0]        status,
  output logic [ID_W-1:0]        echo_id,
  output logic [ROW_W-1:0]       placed_row,
  output logic [SLOT_W-1:0]      placed_slot,
  input  cmd_t                   cmd,
  output sts_t                   sts
);

  localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int SCNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int POS_W   = ((SLOT_AW > WIDTH_W) ? SLOT_AW : WIDTH_W) + 1;

  // configuration
  logic [CFG_ROWS_W-1:0]  rows_in_use;
  logic [CFG_SLOTS_W-1:0] slots_in_use;
  logic [RCNT_W-1:0]      nrows;
  logic [SCNT_W-1:0]      nslots;

  // captured word
  logic                   op_q;
  logic [ID_W-1:0]        id_q;
  logic [WIDTH_W-1:0]     run_w;
  logic [ROW_W-1:0]       brow;
  logic [SLOT_W-1:0]      bslot;

  // search state
  logic [ROW_AW-1:0]      start_row;
  logic [ROW_AW-1:0]      cur_row;
  logic [ROW_AW-1:0]      scan_row;
  logic [RCNT_W-1:0]      scan_cnt;
  logic [STEP_W-1:0]      step;
  logic [MAX_SLOTS-1:0]   free_bits;
  logic [MAX_SLOTS:0]     run_start;
  logic [MAX_SLOTS-1:0]   row_data;
  logic [MAX_SLOTS-1:0]   low_bit;
  logic [SLOT_AW-1:0]     first_slot;
  logic                   skip_armed;
  logic [WIDTH_W-1:0]     failed_width;
  st_t                    res_status;

  // map storage
  logic [MAX_ROWS-1:0]    row_valid;
  logic                   rd_valid;
  logic [MAX_SLOTS-1:0]   rd_data;
  logic [MAX_SLOTS-1:0]   rd_eff;
  logic                   ram_we;
  logic                   ram_re;
  logic [ROW_AW-1:0]      ram_waddr;
  logic [ROW_AW-1:0]      ram_raddr;
  logic [MAX_SLOTS-1:0]   ram_wdata;
  logic [ROW_AW-1:0]      blk_addr;
  logic                   blk_ok;

  // combinational helpers
  logic [MAX_SLOTS-1:0]   slot_en;
  logic [MAX_SLOTS-1:0]   free_sh;
  logic [MAX_SLOTS:0]     run_sh;
  logic [MAX_SLOTS-1:0]   run_low;
  logic [SLOT_AW-1:0]     enc_slot;
  logic [POS_W-1:0]       end_pos;
  logic [MAX_SLOTS-1:0]   run_mask;
  logic [ROW_AW-1:0]      scan_row_inc;
  logic [ROW_AW-1:0]      cur_row_inc;

  // Saturate the register values into the legal ranges.
  always_comb begin
    if (rows_in_use == '0) begin
      nrows = RCNT_W'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      nrows = RCNT_W'(MAX_ROWS);
    end else begin
      nrows = RCNT_W'(rows_in_use);
    end
    if (slots_in_use == '0) begin
      nslots = SCNT_W'(1);
    end else if (int'(slots_in_use) > MAX_SLOTS) begin
      nslots = SCNT_W'(MAX_SLOTS);
    end else begin
      nslots = SCNT_W'(slots_in_use);
    end
  end

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      slot_en[s] = (SCNT_W'(s) < nslots);
    end
  end

  assign blk_addr = ROW_AW'(brow);
  assign blk_ok   = (int'(brow) < MAX_ROWS) && (int'(bslot) < MAX_SLOTS);
  assign rd_eff   = rd_valid ? rd_data : '0;

  assign scan_row_inc = (RCNT_W'(scan_row) + RCNT_W'(1) == nrows) ? '0 : scan_row + 1'b1;
  assign cur_row_inc  = (RCNT_W'(cur_row) + RCNT_W'(1) == nrows) ? '0 : cur_row + 1'b1;

  // Doubling step: free_bits holds runs of 2^step, run_start the runs built so far.
  always_comb begin
    free_sh = '0;
    run_sh  = '0;
    for (int j = 0; j < WIDTH_W; j++) begin
      if (step == STEP_W'(j)) begin
        free_sh = free_bits >> (1 << j);
        run_sh  = run_start >> (1 << j);
      end
    end
  end

  assign run_low = run_start[MAX_SLOTS-1:0] & (~run_start[MAX_SLOTS-1:0] + MAX_SLOTS'(1));

  always_comb begin
    enc_slot = '0;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      if (low_bit[s]) begin
        enc_slot = enc_slot | SLOT_AW'(s);
      end
    end
  end

  assign end_pos = POS_W'(first_slot) + POS_W'(run_w);

  always_comb begin
    for (int s = 0; s < MAX_SLOTS; s++) begin
      run_mask[s] = (POS_W'(s) >= POS_W'(first_slot)) && (POS_W'(s) < end_pos);
    end
  end

  // RAM port steering
  assign ram_re    = cmd.rd_block || cmd.rd_row;
  assign ram_raddr = cmd.rd_block ? blk_addr : scan_row;
  assign ram_we    = (cmd.blk_write && blk_ok) || cmd.place_write;
  assign ram_waddr = cmd.place_write ? scan_row : blk_addr;
  assign ram_wdata = cmd.place_write ? (row_data | run_mask)
                                     : (rd_eff | (MAX_SLOTS'(1) << bslot));

  cssfa_ram #(
    .WIDTH (MAX_SLOTS),
    .DEPTH (MAX_ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= ROWS_RESET;
      slots_in_use <= SLOTS_RESET;
      row_valid    <= '0;
      start_row    <= '0;
      skip_armed   <= 1'b0;
      failed_width <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_IN_USE:  rows_in_use  <= CFG_ROWS_W'(cfg_data);
          REG_SLOTS_IN_USE: slots_in_use <= CFG_SLOTS_W'(cfg_data);
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (cmd.place_write && (scan_row == cur_row)) begin
        start_row <= cur_row_inc;
      end
      if (cmd.skip_clear) begin
        skip_armed <= 1'b0;
      end
      if (cmd.skip_arm) begin
        skip_armed   <= 1'b1;
        failed_width <= run_w;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= op;
      id_q  <= item_id;
      run_w <= run_width;
      brow  <= block_row;
      bslot <= block_slot;
    end
    if (ram_re) begin
      rd_valid <= row_valid[ram_raddr];
    end
    if (cmd.norm_start) begin
      cur_row <= start_row;
    end else if (cmd.norm_sub) begin
      cur_row <= ROW_AW'(RCNT_W'(cur_row) - nrows);
    end
    if (cmd.row_init) begin
      scan_row <= cur_row;
      scan_cnt <= '0;
    end else if (cmd.row_next) begin
      scan_row <= scan_row_inc;
      scan_cnt <= scan_cnt + 1'b1;
    end
    if (cmd.load) begin
      row_data  <= rd_eff;
      free_bits <= ~rd_eff & slot_en;
      run_start <= '1;
      step      <= '0;
    end else if (cmd.step) begin
      free_bits <= free_bits & free_sh;
      if (run_w[step]) begin
        run_start <= {1'b0, free_bits} & run_sh;
      end
      step <= step + 1'b1;
    end
    if (cmd.pick) begin
      low_bit <= run_low;
    end
    if (cmd.encode) begin
      first_slot <= enc_slot;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_val;
    end
    if (cmd.out_load) begin
      status  <= res_status;
      echo_id <= id_q;
      if (res_status == ST_PLACED) begin
        placed_row  <= ROW_W'(scan_row);
        placed_slot <= SLOT_W'(first_slot);
      end else begin
        placed_row  <= '0;
        placed_slot <= '0;
      end
    end
  end

  assign sts.op_block  = op_q;
  assign sts.skip_hit  = skip_armed && (run_w >= failed_width);
  assign sts.cur_ge_n  = (RCNT_W'(cur_row) >= nrows);
  assign sts.step_last = (step == STEP_W'(WIDTH_W - 1));
  assign sts.found     = (|run_start[MAX_SLOTS-1:0]) && (run_w != '0);
  assign sts.last_row  = (scan_cnt + RCNT_W'(1) == nrows);
  assign sts.out_free  = !out_valid || !out_stall;

  `CSSFA_ASSERT_NOW(a_load_when_free, cmd.out_load, !out_valid || !out_stall, "result register overwritten")
  `CSSFA_ASSERT_NOW(a_pick_onehot, cmd.encode, $onehot(low_bit), "picked start is not a single slot")
  `CSSFA_ASSERT_NOW(a_run_on_free, cmd.place_write, ((run_mask & row_data) == '0) && (|run_mask), "placed run overlaps used slots")

endmodule

@@ rtl/contiguous_slot_first_fit_allocator_core.sv @@
// A block request reads and rewrites its map row; a skipped allocate goes straight to the result.
// An allocate first wraps the start row back into range if rows_in_use shrank, then scans rows
// from there until a run is found and written back or every row in use has been searched.
// One item at a time; each row costs one map RAM read, 8 run-doubling steps and a pick.
// Reset (rst, synchronous): map rows read as free, start row and skip cleared,
// rows_in_use 16, slots_in_use 128, no result pending.
module contiguous_slot_first_fit_allocator_core import cssfa_pkg::*; #(
  parameter int MAX_ROWS  = DEF_MAX_ROWS,
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [ID_W-1:0]       item_id,
  input  logic [WIDTH_W-1:0]    run_width,
  input  logic [ROW_W-1:0]      block_row,
  input  logic [SLOT_W-1:0]     block_slot,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ST_W-1:0]       status,
  output logic [ID_W-1:0]       echo_id,
  output logic [ROW_W-1:0]      placed_row,
  output logic [SLOT_W-1:0]     placed_slot
);

  // The controller walks a request through decide, row scan and write-back;
  // the datapath owns the map RAM, the run detector and the result register.
  cmd_t cmd;
  sts_t sts;

  cssfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Each row is read once, then free runs are grown by doubling: after the
  // eight steps every set bit marks a start of run_width free slots. Take the
  // lowest one, mark the run, and hold the result until the sink takes it.
  // A new request word is taken while an old result still waits.
  cssfa_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .item_id     (item_id),
    .run_width   (run_width),
    .block_row   (block_row),
    .block_slot  (block_slot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .echo_id     (echo_id),
    .placed_row  (placed_row),
    .placed_slot (placed_slot),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
